### hw/rtl/lsbbp_pkg.sv
// Package for the LSB-first bit packer with pad.
// Holds the field widths, the request codes, the pad constants and the result type.
// Depends on nothing; imported by lsb_first_bit_packer_with_pad.
package lsbbp_pkg;

  localparam int unsigned WORD_BITS  = 8;
  localparam int unsigned COUNT_CLIP = (WORD_BITS < 8) ? WORD_BITS : 8;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned PTR_W   = 19;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_CLOSE  = 1'b1;

  localparam logic [7:0]       PAD_ALIGNED = 8'hFE;
  localparam logic [CAP_W-1:0] CAP_RESET   = 16'hFFFF;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [3:0]       bits_accepted;
    logic [CAP_W-1:0] stream_bytes;
    logic             closed;
  } res_t;

endpackage

### hw/rtl/lsb_first_bit_packer_with_pad.sv
// Top level of the LSB-first bit packer with pad.
// Holds the input register, the packing logic, the stream state and the result register.
// Depends on lsbbp_pkg.
//
// Each request on the in_ channel either appends 0 to 8 bits of data to a byte
// stream, least significant bit first, or closes the stream. An append result
// reports the bits actually taken after the count and capacity limits and
// carries a byte whenever one fills. A close result, marked by out_tlast, carries
// the pad byte and the stream length in bytes, and the next request starts a new stream.
// The cfg_ channel writes the buffer capacity in bytes; it is always ready. The
// user must write it only while the block is idle; the block does not enforce this.
// A request accepted at a clock edge is captured in the input register and its
// result is then registered in the result register, which drives out_tvalid.
// One request is taken per cycle while out_tready stays high; the bit pointer
// and partial byte update with the result register. When out_tready is low the result
// register holds, then the input register fills, then in_tready drops.
// Reset empties both registers, clears the stream and sets the capacity to 65535.
module lsb_first_bit_packer_with_pad
  import lsbbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,       // capacity_bytes
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,       // data_bits[7:0], bit_count[11:8], zero
  input  logic                   in_tuser,       // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,      // out_byte, bits_accepted, stream_bytes, zero
  output logic                   out_tuser,      // byte_valid
  output logic                   out_tlast       // closed
);

  logic [CAP_W-1:0]   capacity_r;
  logic               s1_valid_r;
  logic               s1_func_r;
  logic [7:0]         s1_data_r;
  logic [3:0]         s1_cnt_r;
  logic               out_valid_r;
  res_t               res_r;
  res_t               res_nxt;
  logic [7:0]         partial_r;
  logic [7:0]         partial_nxt;
  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   ptr_nxt;
  logic               s2_ready;
  logic               s1_adv;
  logic [PTR_W-1:0]   limit;
  logic [PTR_W-1:0]   room;
  logic [3:0]         cnt_clip;
  logic [3:0]         acc;
  logic [2:0]         ofs;
  logic [8:0]         mask9;
  logic [15:0]        merged;
  logic [4:0]         fill;
  logic [7:0]         low_mask;
  logic [7:0]         pad;

  assign cfg_ready = 1'b1;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r <= in_tuser;
      s1_data_r <= in_tdata[7:0];
      s1_cnt_r  <= in_tdata[11:8];
    end
  end

  always_comb begin
    ofs      = ptr_r[2:0];
    limit    = (capacity_r == '0) ? '0 : ({capacity_r, 3'b000} - PTR_W'(1));
    room     = (ptr_r < limit) ? (limit - ptr_r) : '0;
    cnt_clip = (s1_cnt_r > 4'(COUNT_CLIP)) ? 4'(COUNT_CLIP) : s1_cnt_r;
    acc      = (room < PTR_W'(cnt_clip)) ? room[3:0] : cnt_clip;
    mask9    = (9'd1 << acc) - 9'd1;
    merged   = {8'h00, partial_r} | ({8'h00, s1_data_r & mask9[7:0]} << ofs);
    fill     = {2'b00, ofs} + {1'b0, acc};
    low_mask = 8'((9'd1 << ofs) - 9'd1);
    pad      = (ofs != 3'd0) ?
               ((partial_r & low_mask) | 8'(8'hFF << ({1'b0, ofs} + 4'd1))) : PAD_ALIGNED;

    res_nxt     = '0;
    partial_nxt = partial_r;
    ptr_nxt     = ptr_r;
    case (s1_func_r)
      FUNC_CLOSE: begin
        res_nxt.out_byte     = pad;
        res_nxt.byte_valid   = 1'b1;
        res_nxt.stream_bytes = ptr_r[PTR_W-1:3] + CAP_W'(1);
        res_nxt.closed       = 1'b1;
        partial_nxt          = '0;
        ptr_nxt              = '0;
      end
      default: begin
        res_nxt.bits_accepted = acc;
        if (fill >= 5'd8) begin
          res_nxt.out_byte   = merged[7:0];
          res_nxt.byte_valid = 1'b1;
          partial_nxt        = merged[15:8];
        end else begin
          partial_nxt = merged[7:0];
        end
        ptr_nxt = ptr_r + PTR_W'(acc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        partial_r <= partial_nxt;
        ptr_r     <= ptr_nxt;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, res_r.stream_bytes, res_r.bits_accepted, res_r.out_byte};
  assign out_tuser  = res_r.byte_valid;
  assign out_tlast  = res_r.closed;

`ifndef SYNTHESIS
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r >> ptr_r[2:0]) == 8'h00)
    else $error("partial byte holds bits above the bit offset");

  a_close_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser && out_tdata[11:8] == 4'd0)
    else $error("close result without pad byte or with accepted bits");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_func_r == FUNC_CLOSE |=> ptr_r == '0 && partial_r == '0)
    else $error("stream state not cleared after close");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] <= 4'(COUNT_CLIP))
    else $error("accepted bit count above the clip");
`endif

endmodule
